@@ src/ivr_pkg.sv @@
// Shared constants of the image value rescaler.
`default_nettype none
package ivr_pkg;

  localparam int unsigned BufferDepth = 4096;
  localparam int unsigned AddrW       = $clog2(BufferDepth);
  localparam int unsigned CountW      = $clog2(BufferDepth + 1);

  localparam int unsigned PixelW  = 16;
  localparam int unsigned ResultW = 17;
  localparam int unsigned OutTdataW = ((ResultW + 7) / 8) * 8;

  // Register indexes
  localparam logic REG_SCALE_MODE = 1'b0;
  localparam logic REG_MAX_PIXEL  = 1'b1;

  // Request kinds carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Scale modes
  localparam logic MODE_SIMPLE   = 1'b0;
  localparam logic MODE_ACCURATE = 1'b1;

  localparam logic [15:0] MAX_PIXEL_RESET = 16'd255;
  localparam logic [15:0] MIN_SEEN_RESET  = 16'h7FFF;
  localparam logic [15:0] MAX_SEEN_RESET  = 16'h8000;

endpackage
`default_nettype wire

@@ src/image_value_rescaler.sv @@
// Min/max rescaler of one channel of signed pixels, with a shared multiply and divide sequencer.
//
// Load requests (tuser = 0) store one signed pixel each in a 4096 x 16 pixel memory and
// track the channel minimum and maximum; the pixel flagged by tlast closes the channel.
// A load returns nothing and the block stays ready; a load after a closed channel starts a new
// one. Read requests (tuser = 1) on a closed channel return the stored pixels in order,
// rescaled, and tlast marks the final one before the sequence wraps. An accurate-mode read
// steps through the memory read, the shift, the 16 x 16 multiply, the restoring divider,
// which retires one quotient bit per cycle, and the handoff of the result to the output
// register; the next request is taken only after the handoff. A simple-mode read, and an
// accurate-mode read whose shifted maximum is zero, skip the multiply and the divider. The
// handoff waits while the previous result is still held by the sink. The memory holds no
// reset value and needs no clearing pass. Results sit in an output register, so loads keep
// being taken while a result waits for the sink.
`default_nettype none
module image_value_rescaler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] pixel
  input  wire logic        s_axis_tuser,   // [0] func
  input  wire logic        s_axis_tlast,   // last_pixel
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [ivr_pkg::OutTdataW-1:0] m_axis_tdata,  // [16:0] scaled_pixel, rest zero
  output logic             m_axis_tlast    // last_result
);

  localparam int unsigned AW = ivr_pkg::AddrW;
  localparam int unsigned CW = ivr_pkg::CountW;
  localparam int unsigned RW = ivr_pkg::ResultW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // configuration
  logic        scale_mode_q;
  logic [15:0] max_pixel_q;

  // channel state
  logic [15:0]   min_q, min_d;
  logic [15:0]   max_q, max_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          loaded_q, loaded_d;

  // sequencer and datapath
  logic [2:0]    state_q, state_d;
  logic [3:0]    step_q, step_d;
  logic          fin_q, fin_d;
  logic [15:0]   s_q, s_d;
  logic [15:0]   m_q, m_d;
  logic [15:0]   rem_q, rem_d;
  logic [15:0]   quo_q, quo_d;
  logic [RW-1:0] res_q, res_d;

  logic          out_valid_q, out_valid_d;
  logic [RW-1:0] out_data_q;
  logic          out_last_q;

  // memory
  logic [15:0]   pixel_mem [ivr_pkg::BufferDepth];
  logic [15:0]   rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic          in_fire;
  logic          out_fire;

  // load helpers
  logic [CW-1:0] fill_eff;
  logic [15:0]   min_eff;
  logic [15:0]   max_eff;
  logic [AW-1:0] rd_start;

  // arithmetic helpers
  logic signed [16:0] min_ext;
  logic signed [16:0] max_ext;
  logic signed [16:0] pix_ext;
  logic signed [16:0] shift_amt;
  logic signed [16:0] shifted_pix;
  logic signed [16:0] shifted_max;
  logic signed [17:0] simple_sum;
  logic signed [17:0] simple_half;
  logic [31:0]        product;
  logic [16:0]        partial;
  logic [16:0]        trial;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ivr_pkg::OutTdataW - RW){1'b0}}, out_data_q};
  assign m_axis_tlast  = out_last_q;

  // a closed channel restarts on the next load
  assign fill_eff = loaded_q ? '0 : fill_q;
  assign min_eff  = loaded_q ? ivr_pkg::MIN_SEEN_RESET : min_q;
  assign max_eff  = loaded_q ? ivr_pkg::MAX_SEEN_RESET : max_q;
  assign rd_start = ({1'b0, rd_idx_q} >= fill_q) ? '0 : rd_idx_q;

  assign min_ext     = {min_q[15], min_q};
  assign max_ext     = {max_q[15], max_q};
  assign pix_ext     = {rd_data_q[15], rd_data_q};
  assign shift_amt   = min_q[15] ? (17'sd0 - min_ext) : min_ext;
  assign shifted_pix = pix_ext + shift_amt;
  assign shifted_max = max_ext + shift_amt;
  assign simple_sum  = {{2{rd_data_q[15]}}, rd_data_q} + {2'b00, max_pixel_q};
  assign simple_half = (simple_sum + {17'd0, simple_sum[17]}) >>> 1;
  assign product     = {16'd0, s_q} * {16'd0, max_pixel_q};
  assign partial     = {rem_q, quo_q[15]};
  assign trial       = partial - {1'b0, m_q};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    fin_d       = fin_q;
    s_d         = s_q;
    m_d         = m_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_d       = res_q;
    min_d       = min_q;
    max_d       = max_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    loaded_d    = loaded_q;
    out_valid_d = out_valid_q && !out_fire;
    mem_we      = 1'b0;
    mem_waddr   = fill_eff[AW-1:0];
    mem_re      = 1'b0;
    mem_raddr   = rd_start;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == ivr_pkg::FUNC_LOAD) begin
            fill_d   = fill_eff;
            min_d    = min_eff;
            max_d    = max_eff;
            rd_idx_d = loaded_q ? '0 : rd_idx_q;
            loaded_d = s_axis_tlast;
            if (fill_eff < CW'(ivr_pkg::BufferDepth)) begin
              mem_we = 1'b1;
              fill_d = fill_eff + 1'b1;
              if ($signed(s_axis_tdata) < $signed(min_eff)) min_d = s_axis_tdata;
              if ($signed(s_axis_tdata) > $signed(max_eff)) max_d = s_axis_tdata;
            end
          end else if (loaded_q && (fill_q != '0)) begin
            mem_re   = 1'b1;
            fin_d    = (({1'b0, rd_start} + 1'b1) == fill_q);
            rd_idx_d = fin_d ? '0 : rd_start + 1'b1;
            state_d  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (scale_mode_q == ivr_pkg::MODE_SIMPLE) begin
          res_d   = simple_half[RW-1:0];
          state_d = ST_DONE;
        end else if (shifted_max[15:0] == '0) begin
          // degenerate range: pass the shifted pixel through
          res_d   = {1'b0, shifted_pix[15:0]};
          state_d = ST_DONE;
        end else begin
          s_d     = shifted_pix[15:0];
          m_d     = shifted_max[15:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // shifted pixel never exceeds shifted max, so the quotient fits 16 bits
        rem_d   = product[31:16];
        quo_d   = product[15:0];
        step_d  = 4'd15;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[16]) begin
          rem_d = trial[15:0];
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = partial[15:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          res_d   = {1'b0, quo_d};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q <= ivr_pkg::MODE_ACCURATE;
      max_pixel_q  <= ivr_pkg::MAX_PIXEL_RESET;
      min_q        <= ivr_pkg::MIN_SEEN_RESET;
      max_q        <= ivr_pkg::MAX_SEEN_RESET;
      fill_q       <= '0;
      rd_idx_q     <= '0;
      loaded_q     <= 1'b0;
      state_q      <= ST_IDLE;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ivr_pkg::REG_SCALE_MODE: scale_mode_q <= cfg_data_i[0];
          ivr_pkg::REG_MAX_PIXEL:  max_pixel_q  <= cfg_data_i;
          default: ;
        endcase
      end
      min_q       <= min_d;
      max_q       <= max_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      loaded_q    <= loaded_d;
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    s_q   <= s_d;
    m_q   <= m_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
    if ((state_q == ST_DONE) && (!out_valid_q || out_fire)) begin
      out_data_q <= res_q;
      out_last_q <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pixel_mem[mem_waddr] <= s_axis_tdata;
    end
    if (mem_re) begin
      rd_data_q <= pixel_mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_image_value_rescaler.sv @@
// Self-checking testbench of the image value rescaler: directed table and random channels.
module tb_image_value_rescaler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit  = 2000;
  localparam int SettleTicks = 40;
  localparam int RandomItems = 1200;

  typedef struct packed {
    logic [16:0] value;
    logic        last;
  } rescaled_t;

  // fn, pixel, tlast, typed, expected value, expected last, cfg write, cfg index, cfg data
  typedef struct packed {
    logic        fn;
    logic [15:0] px;
    logic        lst;
    logic        typed;
    logic [16:0] want_val;
    logic        want_last;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_val;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] pixel
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [ivr_pkg::OutTdataW-1:0] m_axis_tdata; // [16:0] scaled_pixel, rest zero
  logic        m_axis_tlast;

  // Predictor state
  logic signed [15:0] pixel_mem [ivr_pkg::BufferDepth];
  int   min_seen_q = 32767;
  int   max_seen_q = -32768;
  int   fill_cnt = 0;
  int   rd_idx = 0;
  bit   channel_closed = 1'b0;
  logic scale_mode_q = ivr_pkg::MODE_ACCURATE;
  logic [15:0] max_pixel_q = ivr_pkg::MAX_PIXEL_RESET;

  rescaled_t pending_results [$];
  int mismatches = 0;
  int items_done = 0;
  int results_seen = 0;
  int channels_run = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 28;
  int sink_idle_pct = 49;

  directed_row_t stim_table [24] = '{
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_LOAD, 16'h8000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'hFFFF, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_LOAD, 16'h7FFF, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd255, 1'b1, 1'b0,
      ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    // new channel of one pixel: zero shifted maximum
    '{ivr_pkg::FUNC_LOAD, 16'hFF9C, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b1, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b1, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    // positive minimum still shifts up by its magnitude
    '{ivr_pkg::FUNC_LOAD, 16'd100, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_LOAD, 16'd300, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_LOAD, 16'h8000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b1,
      ivr_pkg::REG_SCALE_MODE, 16'(ivr_pkg::MODE_SIMPLE)},
    '{ivr_pkg::FUNC_LOAD, 16'h7FFF, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b1,
      ivr_pkg::REG_MAX_PIXEL, 16'hFFFF},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    // zero max_pixel_value: simple mode halves the pixel
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'h1C000, 1'b0, 1'b1,
      ivr_pkg::REG_MAX_PIXEL, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b0, 1'b1,
      ivr_pkg::REG_SCALE_MODE, 16'(ivr_pkg::MODE_ACCURATE)},
    '{ivr_pkg::FUNC_READ, 16'h0000, 1'b0, 1'b1, 17'd0, 1'b1, 1'b0, ivr_pkg::REG_SCALE_MODE, 16'd0}
  };

  image_value_rescaler u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [16:0] rescaled_value(input logic signed [15:0] px);
    int  r;
    int  shift_amt;
    int  shifted;
    int  span;
    longint quot;
    if (scale_mode_q == ivr_pkg::MODE_SIMPLE) begin
      r = (int'(px) + int'(max_pixel_q)) / 2;
      return r[16:0];
    end
    shift_amt = (min_seen_q < 0) ? -min_seen_q : min_seen_q;
    shifted = int'(px) + shift_amt;
    span = max_seen_q + shift_amt;
    if (span == 0) return shifted[16:0];
    quot = (longint'(shifted) * longint'(max_pixel_q)) / longint'(span);
    return quot[16:0];
  endfunction

  // Advance the channel state by one request; returns 1 when a rescaled pixel is due.
  function automatic bit rescale_request(input logic fn, input logic signed [15:0] px,
                                         input logic lst, output rescaled_t res);
    res = '0;
    if (fn == ivr_pkg::FUNC_LOAD) begin
      if (channel_closed) begin
        min_seen_q = 32767;
        max_seen_q = -32768;
        fill_cnt = 0;
        rd_idx = 0;
        channel_closed = 1'b0;
      end
      // drop pixels beyond the buffer, but still honor the last mark
      if (fill_cnt < ivr_pkg::BufferDepth) begin
        pixel_mem[fill_cnt] = px;
        fill_cnt++;
        if (int'(px) < min_seen_q) min_seen_q = int'(px);
        if (int'(px) > max_seen_q) max_seen_q = int'(px);
      end
      if (lst) channel_closed = 1'b1;
      return 1'b0;
    end
    if (!channel_closed || fill_cnt == 0) return 1'b0;
    if (rd_idx >= fill_cnt) rd_idx = 0;
    res.value = rescaled_value(pixel_mem[rd_idx]);
    res.last = (rd_idx + 1 == fill_cnt);
    rd_idx = res.last ? 0 : rd_idx + 1;
    return 1'b1;
  endfunction

  task automatic send_request(input logic fn, input logic [15:0] px, input logic lst,
                              input bit typed, input rescaled_t typed_res);
    rescaled_t res;
    bit        due;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fn;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    due = rescale_request(fn, px, lst, res);
    if (due) pending_results.push_back(typed ? typed_res : res);
    items_done++;
  endtask

  // Hold requests off until every result is back and the block has gone quiet.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ivr_pkg::REG_SCALE_MODE) scale_mode_q = val[0];
    else max_pixel_q = val;
  endtask

  always @(posedge clk_i) begin
    rescaled_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result scaled_pixel %0d last_result %0b",
               $signed(m_axis_tdata[16:0]), m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[16:0] !== want.value) begin
          $error("scaled_pixel expected %0d actual %0d",
                 $signed(want.value), $signed(m_axis_tdata[16:0]));
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_result expected %0b actual %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          n;
    int          reads;
    int          style;
    int          spread;
    int          start_items;
    bit          first;
    logic [15:0] base;
    logic [15:0] top;
    logic [15:0] px;
    logic        lst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].cfg_we) begin
        settle_block();
        write_reg(stim_table[i].cfg_idx, stim_table[i].cfg_val);
      end
      send_request(stim_table[i].fn, stim_table[i].px, stim_table[i].lst, stim_table[i].typed,
                   '{stim_table[i].want_val, stim_table[i].want_last});
    end

    start_items = items_done;
    first = 1'b1;
    while (items_done - start_items < RandomItems) begin
      if (items_done - start_items >= 2 * RandomItems / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else if (items_done - start_items >= RandomItems / 3) begin
        src_idle_pct = 49;
        sink_idle_pct = 28;
      end
      if (first || $urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: top = 16'd1;
          1: top = 16'hFFFF;
          2: top = ivr_pkg::MAX_PIXEL_RESET;
          default: top = 16'($urandom_range(65535, 1));
        endcase
        settle_block();
        write_reg(ivr_pkg::REG_SCALE_MODE, 16'($urandom_range(1)));
        write_reg(ivr_pkg::REG_MAX_PIXEL, top);
        first = 1'b0;
      end
      channels_run++;
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      style = $urandom_range(2);
      base = 16'($urandom);
      spread = $urandom_range(4000);
      for (int i = 0; i < n; i++) begin
        case (style)
          0: px = 16'($urandom);
          1: px = base + 16'($urandom_range(spread));
          default: px = 16'($urandom_range(2000, 1));
        endcase
        // now and then a stray read or a missing last mark
        if ($urandom_range(19) == 0)
          send_request(ivr_pkg::FUNC_READ, 16'($urandom), 1'($urandom), 1'b0, '0);
        lst = (i == n - 1) && ($urandom_range(9) != 0);
        send_request(ivr_pkg::FUNC_LOAD, px, lst, 1'b0, '0);
      end
      reads = $urandom_range(2 * n + 1);
      for (int i = 0; i < reads; i++)
        send_request(ivr_pkg::FUNC_READ, 16'($urandom), 1'($urandom), 1'b0, '0);
    end

    settle_block();
    $display("Checked %0d rescaled pixels from %0d requests: directed edge cases",
             results_seen, items_done);
    $display("and %0d random channels in both scale modes.", channels_run);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ image_value_rescaler.f @@
src/ivr_pkg.sv
src/image_value_rescaler.sv
tb/tb_image_value_rescaler.sv
